FILE: hdl/weighted_edit_distance_core_macros.svh
// Assertion macros shared by the weighted edit distance RTL.
`ifndef WEIGHTED_EDIT_DISTANCE_CORE_MACROS_SVH
`define WEIGHTED_EDIT_DISTANCE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define WED_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define WED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/wed_pkg.sv
// Types and constants of the weighted edit distance core.
`default_nettype none

package wed_pkg;

	localparam int unsigned COST_W = 10;
	localparam int unsigned SYM_W  = 8;
	localparam int unsigned ACT_W  = 2;
	localparam int unsigned WGT_W  = 4;
	localparam int unsigned IDX_W  = 2;

	typedef logic [COST_W-1:0] cost_t;
	typedef logic [SYM_W-1:0]  sym_t;
	typedef logic [ACT_W-1:0]  act_t;
	typedef logic [WGT_W-1:0]  wgt_t;
	typedef logic [IDX_W-1:0]  idx_t;

	// input word actions
	localparam act_t ACT_SRC = 2'd0;
	localparam act_t ACT_TGT = 2'd1;
	localparam act_t ACT_RUN = 2'd2;

	// register indexes
	localparam idx_t REG_DEL = 2'd0;
	localparam idx_t REG_INS = 2'd1;
	localparam idx_t REG_SUB = 2'd2;

	localparam wgt_t DEL_RESET = 4'd2;
	localparam wgt_t INS_RESET = 4'd3;
	localparam wgt_t SUB_RESET = 4'd4;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_INIT     = 6'b000010,
		S_ROWSTART = 6'b000100,
		S_ROW0     = 6'b001000,
		S_CELL     = 6'b010000,
		S_DONE     = 6'b100000
	} state_t;

	// add a weight to a cost, clamp at the all-ones cost
	function automatic cost_t sat_add(input cost_t a, input wgt_t b);
		logic [COST_W:0] sum;
		sum = {1'b0, a} + {{(COST_W + 1 - WGT_W){1'b0}}, b};
		return sum[COST_W] ? '1 : sum[COST_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hdl/wed_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module wed_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/weighted_edit_distance_core.sv
// Weighted edit distance core: string loader, row-by-row cost sequencer, result register.
// Append word: accepted while idle; in_ready stays high while idle.
// Compute word with S source and T target chars: the single cell unit updates one cost cell
// per cycle in S_INIT, S_ROW0 and S_CELL through the row RAM; in_ready stays low for that run
// and while a finished result waits for the output register.
// Reset clears lengths, the dropped flag, out_valid and loads weights 2/3/4; RAMs are not cleared.
`default_nettype none
`include "weighted_edit_distance_core_macros.svh"

module weighted_edit_distance_core #(
	parameter int unsigned MAX_LEN = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// input words
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire wed_pkg::act_t action,
	input  wire wed_pkg::sym_t symbol,
	// result words
	output logic               out_valid,
	input  wire logic          out_ready,
	output wed_pkg::cost_t     total_cost,
	output logic               overflow,
	// register writes
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire wed_pkg::idx_t cfg_index,
	input  wire wed_pkg::wgt_t cfg_data
);

	import wed_pkg::*;

	localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
	localparam int unsigned AW    = MAX_LEN > 1 ? $clog2(MAX_LEN) : 1;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

	state_t state_q;

	// weights
	wgt_t del_q, ins_q, sub_q;

	// string bookkeeping
	logic [LEN_W-1:0] src_len_q, tgt_len_q;
	logic             dropped_q;

	// sequencer counters: i walks source rows, j walks target columns
	logic [LEN_W-1:0] i_q, j_q;
	logic [LEN_W-1:0] i_m1;

	// cell unit operands held between cycles
	cost_t left_q, diag_q, result_q;
	sym_t  sc_q;

	// output register
	logic  out_valid_q;
	cost_t cost_q;
	logic  ovf_q;

	// RAM ports
	logic             src_we, tgt_we, row_we;
	logic [AW-1:0]    src_raddr, tgt_raddr;
	logic [LEN_W-1:0] row_waddr, row_raddr;
	sym_t             src_rd, tgt_rd;
	cost_t            row_rd, row_wd;

	// cell unit results
	cost_t init_val, row0_val, cell_val;
	cost_t del_c, ins_c, sub_c, min_di;

	logic in_acc, slot_free, j_last, i_last;

	assign in_acc    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || out_ready;
	assign j_last    = (j_q == tgt_len_q);
	assign i_last    = (i_q == src_len_q);
	assign i_m1      = i_q - 1'b1;

	assign out_valid  = out_valid_q;
	assign total_cost = cost_q;
	assign overflow   = ovf_q;

	// ---------------------------------------------------------------------
	// Shared cell unit: one cost cell per cycle
	// ---------------------------------------------------------------------
	always_comb begin
		init_val = (j_q == '0) ? '0 : sat_add(left_q, ins_q);
		row0_val = sat_add(row_rd, del_q);
		del_c    = sat_add(row_rd, del_q);
		ins_c    = sat_add(left_q, ins_q);
		sub_c    = (sc_q == tgt_rd) ? diag_q : sat_add(diag_q, sub_q);
		min_di   = (del_c < ins_c) ? del_c : ins_c;
		cell_val = (min_di < sub_c) ? min_di : sub_c;
	end

	// ---------------------------------------------------------------------
	// RAM addressing
	// ---------------------------------------------------------------------
	always_comb begin
		src_we    = in_acc && (action == ACT_SRC) && (src_len_q < LEN_MAX);
		tgt_we    = in_acc && (action == ACT_TGT) && (tgt_len_q < LEN_MAX);
		src_raddr = (state_q == S_ROWSTART) ? i_m1[AW-1:0] : '0;
		row_we    = (state_q == S_INIT) || (state_q == S_ROW0) || (state_q == S_CELL);
		row_waddr = (state_q == S_ROW0) ? '0 : j_q;
		row_raddr = '0;
		tgt_raddr = '0;
		row_wd    = cell_val;
		unique case (state_q)
			S_INIT: begin
				row_wd = init_val;
			end
			S_ROW0: begin
				row_wd    = row0_val;
				row_raddr = LEN_W'(1);
			end
			S_CELL: begin
				// fetch the next column's operands while this one resolves
				if (!j_last) begin
					row_raddr = LEN_W'(j_q + 1'b1);
					tgt_raddr = j_q[AW-1:0];
				end
			end
			default: begin
				row_wd = cell_val;
			end
		endcase
	end

	wed_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_src_ram (
		.clk   (clk),
		.we    (src_we),
		.waddr (src_len_q[AW-1:0]),
		.wdata (symbol),
		.raddr (src_raddr),
		.rdata (src_rd)
	);

	wed_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_tgt_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (tgt_len_q[AW-1:0]),
		.wdata (symbol),
		.raddr (tgt_raddr),
		.rdata (tgt_rd)
	);

	wed_ram #(.WIDTH(COST_W), .DEPTH(MAX_LEN + 1)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wd),
		.raddr (row_raddr),
		.rdata (row_rd)
	);

	// ---------------------------------------------------------------------
	// Sequencer and control state
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			del_q       <= DEL_RESET;
			ins_q       <= INS_RESET;
			sub_q       <= SUB_RESET;
			src_len_q   <= '0;
			tgt_len_q   <= '0;
			dropped_q   <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// take register writes at any time
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_DEL: del_q <= cfg_data;
					REG_INS: ins_q <= cfg_data;
					REG_SUB: sub_q <= cfg_data;
					default: ;
				endcase
			end

			// raise the result when a run ends, drop it once the consumer takes it
			if ((state_q == S_DONE) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (action)
							ACT_SRC: begin
								if (src_len_q < LEN_MAX) begin
									src_len_q <= src_len_q + 1'b1;
								end else begin
									dropped_q <= 1'b1;
								end
							end
							ACT_TGT: begin
								if (tgt_len_q < LEN_MAX) begin
									tgt_len_q <= tgt_len_q + 1'b1;
								end else begin
									dropped_q <= 1'b1;
								end
							end
							ACT_RUN: begin
								j_q     <= '0;
								state_q <= S_INIT;
							end
							default: ;
						endcase
					end
				end
				S_INIT: begin
					// first row: running sum of insert weights
					j_q <= j_q + 1'b1;
					if (j_last) begin
						i_q     <= LEN_W'(1);
						state_q <= (src_len_q == '0) ? S_DONE : S_ROWSTART;
					end
				end
				S_ROWSTART: begin
					state_q <= S_ROW0;
				end
				S_ROW0: begin
					j_q <= LEN_W'(1);
					if (tgt_len_q == '0) begin
						i_q     <= i_q + 1'b1;
						state_q <= i_last ? S_DONE : S_ROWSTART;
					end else begin
						state_q <= S_CELL;
					end
				end
				S_CELL: begin
					j_q <= j_q + 1'b1;
					if (j_last) begin
						i_q     <= i_q + 1'b1;
						state_q <= i_last ? S_DONE : S_ROWSTART;
					end
				end
				S_DONE: begin
					// hold until the output register is free, then clear the strings
					if (slot_free) begin
						src_len_q   <= '0;
						tgt_len_q   <= '0;
						dropped_q   <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Cell operands and result payload
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_INIT: begin
				left_q   <= init_val;
				result_q <= init_val;
			end
			S_ROW0: begin
				diag_q   <= row_rd;
				left_q   <= row0_val;
				sc_q     <= src_rd;
				result_q <= row0_val;
			end
			S_CELL: begin
				diag_q   <= row_rd;
				left_q   <= cell_val;
				result_q <= cell_val;
			end
			default: ;
		endcase
		if ((state_q == S_DONE) && slot_free) begin
			cost_q <= result_q;
			ovf_q  <= dropped_q;
		end
	end

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	`WED_ASSERT_NOW(a_len_bound, 1'b1, (src_len_q <= LEN_MAX) && (tgt_len_q <= LEN_MAX), "string length above capacity")
	`WED_ASSERT_NEXT(a_run_busy, in_acc && (action == ACT_RUN), !in_ready, "ready after a compute word")
	`WED_ASSERT_NOW(a_rose_after_done, $rose(out_valid), $past(state_q == S_DONE), "result without a finished run")
	`WED_ASSERT_NOW(a_cell_col, state_q == S_CELL, (j_q != '0) && (j_q <= tgt_len_q), "column counter out of range")
	`WED_ASSERT_NOW(a_clear_on_emit, $rose(out_valid), (src_len_q == '0) && (tgt_len_q == '0), "strings not cleared on emit")

endmodule

`default_nettype wire

FILE: test/weighted_edit_distance_core_tb.sv
// Self-checking testbench of the weighted edit distance core.
`default_nettype none

module weighted_edit_distance_core_tb;
	import wed_pkg::*;

	localparam int MAX_LEN = 32;
	// worst compute run, with both strings full
	localparam int LONGEST_RUN = (MAX_LEN + 1) + MAX_LEN * (MAX_LEN + 2) + 1;
	// cycles with no word moving on any channel before the run is called hung
	localparam int QUIET_LIMIT = 4 * LONGEST_RUN + 100;
	// pause after the last owed cost is back, before touching registers
	localparam int CFG_PAUSE = 8;
	localparam int PLAN_LEN = 20;
	localparam int PHASES = 6;
	localparam int PHASE_WORDS = 285;
	localparam int unsigned COST_TOP = (1 << COST_W) - 1;

	// codes the package leaves unnamed
	localparam act_t ACT_NONE = 2'd3;
	localparam idx_t REG_NONE = 2'd3;

	typedef struct packed {
		cost_t cost;
		logic  ovf;
	} outcome_t;

	typedef struct packed {
		act_t     act;
		sym_t     sym;
		logic     typed;
		outcome_t want;
	} plan_row_t;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	act_t  action;
	sym_t  symbol;
	logic  out_valid;
	logic  out_ready;
	cost_t total_cost;
	logic  overflow;
	logic  cfg_valid;
	logic  cfg_ready;
	idx_t  cfg_index;
	wgt_t  cfg_data;

	weighted_edit_distance_core #(
		.MAX_LEN(MAX_LEN)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.symbol    (symbol),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.total_cost(total_cost),
		.overflow  (overflow),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the block: loaded strings, weights and the dropped flag.
	sym_t src_text [MAX_LEN];
	sym_t tgt_text [MAX_LEN];
	int   src_len;
	int   tgt_len;
	logic dropped;
	wgt_t del_w;
	wgt_t ins_w;
	wgt_t sub_w;

	// Costs still owed by the block, oldest first.
	outcome_t pending_costs [$];
	int       mismatches;
	int       quiet_cycles;
	int       src_calm;
	int       snk_calm;

	// Directed words, walked in order right after reset with the reset weights
	// (delete 2, insert 3, substitute 4). Rows with typed set carry a cost that
	// follows directly from those weights; the rest go through the predictor.
	plan_row_t plan [PLAN_LEN] = '{
		{ACT_RUN,  8'h00, 1'b1, 10'd0, 1'b0},  // both strings empty
		{ACT_SRC,  8'h00, 1'b0, 10'd0, 1'b0},
		{ACT_SRC,  8'hFF, 1'b0, 10'd0, 1'b0},
		{ACT_RUN,  8'hFF, 1'b1, 10'd4, 1'b0},  // empty target: two deletes
		{ACT_TGT,  8'hFF, 1'b0, 10'd0, 1'b0},
		{ACT_TGT,  8'h00, 1'b0, 10'd0, 1'b0},
		{ACT_TGT,  8'h55, 1'b0, 10'd0, 1'b0},
		{ACT_RUN,  8'h00, 1'b1, 10'd9, 1'b0},  // empty source: three inserts
		{ACT_SRC,  8'hAA, 1'b0, 10'd0, 1'b0},
		{ACT_TGT,  8'hAA, 1'b0, 10'd0, 1'b0},
		{ACT_RUN,  8'h00, 1'b1, 10'd0, 1'b0},  // matching chars are free
		{ACT_SRC,  8'h01, 1'b0, 10'd0, 1'b0},
		{ACT_TGT,  8'h02, 1'b0, 10'd0, 1'b0},
		{ACT_RUN,  8'h00, 1'b1, 10'd4, 1'b0},  // substitute beats delete+insert
		{ACT_NONE, 8'h5A, 1'b0, 10'd0, 1'b0},  // unused action, must leave no trace
		{ACT_SRC,  8'h80, 1'b0, 10'd0, 1'b0},
		{ACT_NONE, 8'hA5, 1'b0, 10'd0, 1'b0},  // unused action mid-string
		{ACT_TGT,  8'h7F, 1'b0, 10'd0, 1'b0},
		{ACT_SRC,  8'h7F, 1'b0, 10'd0, 1'b0},
		{ACT_RUN,  8'h00, 1'b0, 10'd0, 1'b0}
	};

	// Add a weight to a cost, clamp at the top cost.
	function automatic cost_t clamp_add(cost_t c, wgt_t w);
		int unsigned s;
		s = int'(c) + int'(w);
		return (s > COST_TOP) ? cost_t'(COST_TOP) : cost_t'(s);
	endfunction

	// Least weighted cost from source to target, one table row at a time.
	function automatic cost_t edit_cost();
		cost_t row [MAX_LEN + 1];
		cost_t diag;
		cost_t above;
		cost_t by_del;
		cost_t by_ins;
		cost_t by_sub;
		cost_t best;
		row[0] = '0;
		for (int j = 1; j <= tgt_len; j++)
			row[j] = clamp_add(row[j - 1], ins_w);
		for (int i = 1; i <= src_len; i++) begin
			diag = row[0];
			row[0] = clamp_add(row[0], del_w);
			for (int j = 1; j <= tgt_len; j++) begin
				above = row[j];
				by_del = clamp_add(above, del_w);
				by_ins = clamp_add(row[j - 1], ins_w);
				by_sub = (src_text[i - 1] == tgt_text[j - 1]) ? diag : clamp_add(diag, sub_w);
				best = (by_del < by_ins) ? by_del : by_ins;
				row[j] = (by_sub < best) ? by_sub : best;
				diag = above;
			end
		end
		return row[tgt_len];
	endfunction

	// Fold one accepted word into the shadow state; return 1 when it owes a cost.
	function automatic bit absorb_word(act_t a, sym_t s, output outcome_t r);
		r = '0;
		case (a)
			ACT_SRC: begin
				if (src_len < MAX_LEN) begin
					src_text[src_len] = s;
					src_len++;
				end else begin
					dropped = 1'b1;
				end
			end
			ACT_TGT: begin
				if (tgt_len < MAX_LEN) begin
					tgt_text[tgt_len] = s;
					tgt_len++;
				end else begin
					dropped = 1'b1;
				end
			end
			ACT_RUN: begin
				r.cost = edit_cost();
				r.ovf = dropped;
				src_len = 0;
				tgt_len = 0;
				dropped = 1'b0;
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	// Draw the idle cycles before the next word, with calm stretches of
	// back-to-back words now and then.
	function automatic int idle_cycles(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 19);
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Offer one input word; record what it owes once the block takes it.
	// Keep valid high straight into the next word when no gap is drawn.
	task automatic send_word(act_t a, sym_t s, logic typed, outcome_t want);
		int gap;
		outcome_t got;
		gap = idle_cycles(src_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		symbol <= s;
		do @(posedge clk); while (in_ready !== 1'b1);
		if (absorb_word(a, s, got))
			pending_costs.push_back(typed ? want : got);
	endtask

	// Write one register, then drop valid.
	task automatic write_reg(idx_t idx, wgt_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DEL: del_w = val;
			REG_INS: ins_w = val;
			REG_SUB: sub_w = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Drop valid and hold until every owed cost is back and the block is quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_costs.size() != 0) @(posedge clk);
		repeat (CFG_PAUSE) @(posedge clk);
	endtask

	// Compare one taken result word with the oldest owed cost.
	task automatic take_result(cost_t c, logic o);
		outcome_t w;
		if (pending_costs.size() == 0) begin
			flag_mismatch("result word with nothing owed, total_cost", c, 0);
			return;
		end
		w = pending_costs.pop_front();
		if (c !== w.cost)
			flag_mismatch("total_cost", c, w.cost);
		if (o !== w.ovf)
			flag_mismatch("overflow", o, w.ovf);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: end the run if no word moves on any channel for too long.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Result side: stall ready for a drawn number of cycles before each word,
	// keep it high through calm stretches.
	initial begin
		int gap;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = idle_cycles(snk_calm);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			take_result(total_cost, overflow);
		end
	end

	initial begin
		int n_src;
		int n_tgt;
		int src_left;
		int tgt_left;
		int sent;
		bit narrow;
		bit to_src;
		sym_t base;
		sym_t sym;
		wgt_t d;
		wgt_t i;
		wgt_t s;

		mismatches = 0;
		quiet_cycles = 0;
		src_calm = 0;
		snk_calm = 0;
		src_len = 0;
		tgt_len = 0;
		dropped = 1'b0;
		del_w = DEL_RESET;
		ins_w = INS_RESET;
		sub_w = SUB_RESET;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ACT_SRC;
		symbol <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_DEL;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words with the reset weights
		for (int k = 0; k < PLAN_LEN; k++)
			send_word(plan[k].act, plan[k].sym, plan[k].typed, plan[k].want);

		// capacity: overfill the source, overfill the target, then fill both exactly
		for (int c = 0; c < 3; c++) begin
			n_src = (c == 0) ? MAX_LEN + 2 : (c == 1) ? 1 : MAX_LEN;
			n_tgt = (c == 0) ? 1 : (c == 1) ? MAX_LEN + 1 : MAX_LEN;
			for (int k = 0; k < n_src; k++)
				send_word(ACT_SRC, sym_t'($urandom_range(0, 255)), 1'b0, '0);
			for (int k = 0; k < n_tgt; k++)
				send_word(ACT_TGT, sym_t'($urandom_range(0, 255)), 1'b0, '0);
			send_word(ACT_RUN, sym_t'($urandom_range(0, 255)), 1'b0, '0);
		end

		// random phases, each under its own set of weights
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: begin d = 4'd15; i = 4'd15; s = 4'd15; end
				1: begin d = 4'd0;  i = 4'd0;  s = 4'd0;  end
				2: begin d = 4'd15; i = 4'd0;  s = 4'd15; end
				3: begin d = 4'd1;  i = 4'd15; s = 4'd0;  end
				default: begin
					d = wgt_t'($urandom_range(0, 15));
					i = wgt_t'($urandom_range(0, 15));
					s = wgt_t'($urandom_range(0, 15));
				end
			endcase
			write_reg(REG_DEL, d);
			write_reg(REG_INS, i);
			write_reg(REG_SUB, s);
			// unknown index last, so a stray decode would clobber a live weight
			write_reg(REG_NONE, wgt_t'($urandom_range(0, 15)));

			sent = 0;
			while (sent < PHASE_WORDS) begin
				// mostly short strings; now and then strings near, at or past capacity
				if ($urandom_range(0, 19) == 0) begin
					src_left = $urandom_range(MAX_LEN - 2, MAX_LEN + 2);
					tgt_left = $urandom_range(MAX_LEN - 2, MAX_LEN + 2);
				end else begin
					src_left = $urandom_range(0, 6);
					tgt_left = $urandom_range(0, 6);
				end
				// a narrow alphabet makes matching characters common
				narrow = $urandom_range(0, 1);
				base = sym_t'($urandom_range(0, 255));
				while (src_left + tgt_left > 0) begin
					if ($urandom_range(0, 24) == 0)
						send_word(ACT_NONE, sym_t'($urandom_range(0, 255)), 1'b0, '0);
					to_src = (tgt_left == 0) || (src_left > 0 && $urandom_range(0, 1) == 1);
					sym = narrow ? sym_t'(base + $urandom_range(0, 2))
					             : sym_t'($urandom_range(0, 255));
					if (to_src) begin
						send_word(ACT_SRC, sym, 1'b0, '0);
						src_left--;
					end else begin
						send_word(ACT_TGT, sym, 1'b0, '0);
						tgt_left--;
					end
					sent++;
				end
				send_word(ACT_RUN, sym_t'($urandom_range(0, 255)), 1'b0, '0);
				sent++;
			end
		end

		// drain, then give a stray late word time to show up
		in_valid <= 1'b0;
		while (pending_costs.size() != 0) @(posedge clk);
		repeat (LONGEST_RUN) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
